### sv/sipl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipl_pkg
// Types and constants shared by the sorted priority list and its cells.
// ----------------------------------------------------------------------------
package sipl_pkg;

	localparam int SIPL_DEPTH = 16;
	localparam int KEY_W      = 32;
	localparam int PAY_W      = 32;
	localparam int CNT_OUT_W  = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_KEEP   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

	// Operation broadcast to every cell in the accepting cycle
	typedef struct packed {
		logic                 fire;
		op_t                  op;
		logic [KEY_W-1:0]     key;
		logic [PAY_W-1:0]     payload;
		logic [CNT_OUT_W-1:0] keep_count;
	} cmd_t;

endpackage

### sv/sipl_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipl_req_if
// Request channel: operation with key, payload and keep count.
// ----------------------------------------------------------------------------
interface sipl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] sort_key;
	logic [31:0] item_payload;
	logic [4:0]  keep_count;

	modport source (output valid, output operation, output sort_key,
		output item_payload, output keep_count, input ready);
	modport sink (input valid, input operation, input sort_key,
		input item_payload, input keep_count, output ready);
endinterface

### sv/sipl_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipl_rsp_if
// Response channel: popped entry, occupancy and overflow flag.
// ----------------------------------------------------------------------------
interface sipl_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] popped_key;
	logic [31:0] popped_payload;
	logic        popped_valid;
	logic [4:0]  entry_count;
	logic        overflow;

	modport source (output valid, output popped_key, output popped_payload,
		output popped_valid, output entry_count, output overflow, input ready);
	modport sink (input valid, input popped_key, input popped_payload,
		input popped_valid, input entry_count, input overflow, output ready);
endinterface

### sv/sipl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipl_cell
// One slot of the sorted list. Holds an entry and its valid bit, and on each
// transfer loads the new entry, its left neighbor, its right neighbor, or
// holds. A keep that cuts the list to this slot's index or fewer entries clears its valid bit.
// ----------------------------------------------------------------------------
module sipl_cell
	import sipl_pkg::*;
#(
	parameter int INDEX = 0
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cmd_t   cmd,
	input  entry_t prev_ent,
	input  logic   prev_valid,
	input  logic   prev_take,
	input  entry_t next_ent,
	input  logic   next_valid,
	output entry_t ent,
	output logic   valid,
	output logic   take
);

	entry_t ent_q;
	logic   valid_q;
	logic   drop;

	// New entry belongs at or before this slot
	assign take  = !valid_q || (cmd.key <= ent_q.key);
	assign drop  = (cmd.keep_count != '0) && (INDEX >= int'(cmd.keep_count));
	assign ent   = ent_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.fire) begin
			case (cmd.op)
				OP_INSERT: begin
					if (prev_take) begin
						valid_q <= prev_valid;
					end else if (take) begin
						valid_q <= 1'b1;
					end
				end
				OP_KEEP: begin
					if (drop) begin
						valid_q <= 1'b0;
					end
				end
				OP_REMOVE: begin
					valid_q <= next_valid;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fire) begin
			case (cmd.op)
				OP_INSERT: begin
					// shift right behind the insertion point
					if (prev_take) begin
						ent_q <= prev_ent;
					end else if (take) begin
						ent_q <= '{key: cmd.key, payload: cmd.payload};
					end
				end
				OP_REMOVE: begin
					ent_q <= next_ent;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### sv/sorted_insert_priority_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_list
// Sorted list of up to DEPTH key/payload entries in ascending key order,
// built as a row of cells that compare against the request in parallel.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   operation, sort_key, item_payload, keep_count
//  rsp      out  popped_key, popped_payload, popped_valid, entry_count, overflow
//
// One operation per cycle: every cell compares the request key with its own
// key at once and takes the new entry or a neighbor's entry at the transfer.
// The response is registered; a new request is taken whenever the response
// register is empty or being emptied in the same cycle.
// Reset clears the valid bits and the occupancy counter; no clearing pass.
// A stalled response holds req.ready low and the list holds its contents.
// ----------------------------------------------------------------------------
module sorted_insert_priority_list
	import sipl_pkg::*;
#(
	parameter int DEPTH = SIPL_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	sipl_req_if.sink   req,
	sipl_rsp_if.source rsp
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             cmd;
	logic             accept;
	entry_t           ent      [DEPTH];
	entry_t           prev_ent [DEPTH];
	entry_t           next_ent [DEPTH];
	logic [DEPTH-1:0] vld;
	logic [DEPTH-1:0] take;
	logic [DEPTH-1:0] prev_vld;
	logic [DEPTH-1:0] prev_take;
	logic [DEPTH-1:0] next_vld;
	logic             full;

	logic [CNT_W-1:0] occ_q;
	logic [CNT_W-1:0] occ_d;
	logic             rsp_valid_q;
	logic [31:0]      pop_key_q;
	logic [31:0]      pop_pay_q;
	logic             pop_vld_q;
	logic [4:0]       count_q;
	logic             ovf_q;
	logic             pop_hit;
	logic             ovf_hit;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign full      = vld[DEPTH-1];

	assign cmd = '{fire: accept, op: op_t'(req.operation), key: req.sort_key,
		payload: req.item_payload, keep_count: req.keep_count};

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_ent[i]  = '0;
			assign prev_vld[i]  = 1'b0;
			assign prev_take[i] = 1'b0;
		end else begin : g_mid
			assign prev_ent[i]  = ent[i-1];
			assign prev_vld[i]  = vld[i-1];
			assign prev_take[i] = take[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_ent[i] = '0;
			assign next_vld[i] = 1'b0;
		end else begin : g_inner
			assign next_ent[i] = ent[i+1];
			assign next_vld[i] = vld[i+1];
		end

		sipl_cell #(.INDEX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_ent   (prev_ent[i]),
			.prev_valid (prev_vld[i]),
			.prev_take  (prev_take[i]),
			.next_ent   (next_ent[i]),
			.next_valid (next_vld[i]),
			.ent        (ent[i]),
			.valid      (vld[i]),
			.take       (take[i])
		);
	end

	always_comb begin
		occ_d   = occ_q;
		pop_hit = 1'b0;
		ovf_hit = 1'b0;
		case (cmd.op)
			OP_INSERT: begin
				if (full) begin
					ovf_hit = 1'b1;
				end else begin
					occ_d = occ_q + 1'b1;
				end
			end
			OP_KEEP: begin
				if ((cmd.keep_count != '0) && (int'(cmd.keep_count) < int'(occ_q))) begin
					occ_d = CNT_W'(cmd.keep_count);
				end
			end
			OP_REMOVE: begin
				if (vld[0]) begin
					pop_hit = 1'b1;
					occ_d   = occ_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				occ_q       <= occ_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_key_q <= pop_hit ? ent[0].key : '0;
			pop_pay_q <= pop_hit ? ent[0].payload : '0;
			pop_vld_q <= pop_hit;
			count_q   <= CNT_OUT_W'(occ_d);
			ovf_q     <= ovf_hit;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.popped_key     = pop_key_q;
	assign rsp.popped_payload = pop_pay_q;
	assign rsp.popped_valid   = pop_vld_q;
	assign rsp.entry_count    = count_q;
	assign rsp.overflow       = ovf_q;

	// Counter and cell valid bits must agree
	a_empty_match: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) == !vld[0])
		else $error("occupancy zero disagrees with first cell valid");

	a_full_match: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(occ_q) == DEPTH) == full)
		else $error("occupancy full disagrees with last cell valid");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.op == OP_REMOVE) && (occ_q == '0)) |=>
			(!rsp.popped_valid && (rsp.popped_key == '0)))
		else $error("remove from empty list reported an entry");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted priority list. A shadow copy of the list
// predicts every response. The bench covers the corner cases first: empty
// list, equal keys, truncation and a full list. It then runs one long response
// hold-off and random operation mixes, all but one under random idle and stall cycles.
// ----------------------------------------------------------------------------
module tb;
	import sipl_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int HOLD_OFF_CYCLES = 200;

	typedef struct {
		bit [KEY_W-1:0]     key;
		bit [PAY_W-1:0]     payload;
		bit                 popped;
		bit [CNT_OUT_W-1:0] count;
		bit                 ovf;
	} list_reply_t;

	logic clk;
	logic arst_n;

	sipl_req_if req_ch ();
	sipl_rsp_if rsp_ch ();

	sorted_insert_priority_list i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list, slots 0 .. shadow_count-1 in use
	bit [KEY_W-1:0] shadow_keys     [SIPL_DEPTH];
	bit [PAY_W-1:0] shadow_payloads [SIPL_DEPTH];
	int             shadow_count;

	list_reply_t expected_replies[$];
	int          mismatches;
	bit          idling_on;
	int          hold_left;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic list_reply_t apply_list_op(logic [1:0] op, bit [KEY_W-1:0] key,
		bit [PAY_W-1:0] pay, bit [CNT_OUT_W-1:0] keep);
		list_reply_t r;
		int pos;
		int last;
		r = '{default: 0};
		case (op)
			OP_INSERT: begin
				pos = 0;
				while (pos < shadow_count && key > shadow_keys[pos])
					pos++;
				if (shadow_count >= SIPL_DEPTH) begin
					r.ovf = 1'b1;
					last  = SIPL_DEPTH - 1;
				end else begin
					last = shadow_count;
					shadow_count++;
				end
				// a new key above every entry of a full list is itself dropped
				if (pos <= last) begin
					for (int i = last; i > pos; i--) begin
						shadow_keys[i]     = shadow_keys[i-1];
						shadow_payloads[i] = shadow_payloads[i-1];
					end
					shadow_keys[pos]     = key;
					shadow_payloads[pos] = pay;
				end
			end
			OP_KEEP: begin
				if (keep != 0 && int'(keep) < shadow_count)
					shadow_count = int'(keep);
			end
			OP_REMOVE: begin
				if (shadow_count != 0) begin
					r.key     = shadow_keys[0];
					r.payload = shadow_payloads[0];
					r.popped  = 1'b1;
					for (int i = 1; i < shadow_count; i++) begin
						shadow_keys[i-1]     = shadow_keys[i];
						shadow_payloads[i-1] = shadow_payloads[i];
					end
					shadow_count--;
				end
			end
			default: ;
		endcase
		r.count = shadow_count[CNT_OUT_W-1:0];
		return r;
	endfunction

	function automatic void check_field(string name, bit [31:0] want, bit [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%08h, got 0x%08h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		list_reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("response transfer with no operation outstanding");
				mismatches++;
			end else begin
				want = expected_replies.pop_front();
				check_field("popped_key", want.key, rsp_ch.popped_key);
				check_field("popped_payload", want.payload, rsp_ch.popped_payload);
				check_field("popped_valid", 32'(want.popped), 32'(rsp_ch.popped_valid));
				check_field("entry_count", 32'(want.count), 32'(rsp_ch.entry_count));
				check_field("overflow", 32'(want.ovf), 32'(rsp_ch.overflow));
			end
		end
	end

	// Response side: long hold-off first, else random stalls
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_ch.ready = 1'b0;
		end else if (idling_on && $urandom_range(99) < 21) begin
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = 1'b1;
		end
	end

	// Entered and left at a falling edge
	task automatic send_list_op(logic [1:0] op, bit [KEY_W-1:0] key,
		bit [PAY_W-1:0] pay, bit [CNT_OUT_W-1:0] keep);
		if (idling_on && $urandom_range(99) < 21) begin
			req_ch.valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		req_ch.operation    = op;
		req_ch.sort_key     = key;
		req_ch.item_payload = pay;
		req_ch.keep_count   = keep;
		req_ch.valid        = 1'b1;
		do
			@(posedge clk);
		while (!req_ch.ready);
		expected_replies.push_back(apply_list_op(op, key, pay, keep));
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (expected_replies.size() != 0)
			@(negedge clk);
	endtask

	function automatic bit [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40)
			return $urandom_range(15);
		if (r < 50) begin
			case ($urandom_range(3))
				0:       return '0;
				1:       return '1;
				2:       return 32'h7fff_ffff;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	function automatic logic [1:0] pick_op(int insert_pct);
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return OP_UNUSED;
		if (r < 11)
			return OP_KEEP;
		if (r < insert_pct)
			return OP_INSERT;
		return OP_REMOVE;
	endfunction

	task automatic test_empty_list();
		send_list_op(OP_REMOVE, 32'h1234_5678, 32'h9abc_def0, 5'd0);
		send_list_op(OP_UNUSED, '1, '1, '1);
		send_list_op(OP_KEEP, '0, '0, 5'd0);
	endtask

	// Equal keys: newest goes first
	task automatic test_insert_order();
		send_list_op(OP_INSERT, '1, 32'hffff_0001, 5'd0);
		send_list_op(OP_INSERT, '0, '1, 5'd0);
		send_list_op(OP_INSERT, 32'd7, 32'haaaa_aaaa, 5'd0);
		send_list_op(OP_INSERT, 32'd7, 32'h5555_5555, 5'd0);
		send_list_op(OP_REMOVE, '0, '0, 5'd0);
		send_list_op(OP_REMOVE, '0, '0, 5'd0);
	endtask

	task automatic test_keep();
		send_list_op(OP_KEEP, '0, '0, 5'd16);
		send_list_op(OP_KEEP, '0, '0, 5'd1);
	endtask

	task automatic test_full_list();
		for (int i = 1; i < SIPL_DEPTH; i++)
			send_list_op(OP_INSERT, 32'(100 * i), $urandom, 5'd0);
		send_list_op(OP_INSERT, '1, 32'hdead_0001, 5'd0);
		send_list_op(OP_INSERT, 32'd1, 32'hdead_0002, 5'd0);
		send_list_op(OP_INSERT, 32'd1400, 32'hdead_0003, 5'd0);
	endtask

	// Hold responses off so the request side stalls while items keep coming
	task automatic test_backpressure();
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 40; i++)
			send_list_op(pick_op(60), pick_key(), $urandom,
				CNT_OUT_W'($urandom_range(16)));
	endtask

	task automatic test_random_mix(int n_ops);
		int insert_pct;
		insert_pct = 55;
		for (int i = 0; i < n_ops; i++) begin
			// switch between filling, draining and balanced phases
			if (i % 40 == 0) begin
				case ($urandom_range(2))
					0:       insert_pct = 85;
					1:       insert_pct = 30;
					default: insert_pct = 55;
				endcase
			end
			send_list_op(pick_op(insert_pct), pick_key(), $urandom,
				CNT_OUT_W'($urandom_range(16)));
		end
	endtask

	initial begin
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.operation    = OP_INSERT;
		req_ch.sort_key     = '0;
		req_ch.item_payload = '0;
		req_ch.keep_count   = '0;
		rsp_ch.ready        = 1'b0;
		shadow_count        = 0;
		mismatches          = 0;
		hold_left           = 0;
		idling_on           = 1'b1;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_insert_order();
		test_keep();
		test_full_list();
		wait_drained();
		test_backpressure();
		wait_drained();
		test_random_mix(500);
		idling_on = 1'b0;
		test_random_mix(300);
		idling_on = 1'b1;
		test_random_mix(400);

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

### filelist.f
sv/sipl_pkg.sv
sv/sipl_req_if.sv
sv/sipl_rsp_if.sv
sv/sipl_cell.sv
sv/sorted_insert_priority_list.sv
bench/tb.sv
